// ===== src/rpwc_pkg.sv =====
// Shared types and constants for the RC pulse-width capture block.
// Used by every module under src; depends on nothing.
package rpwc_pkg;

    // Fixed field widths
    localparam int COUNT_BITS = 16;
    localparam int WIDTH_BITS = 16;
    localparam int CH_BITS    = 2;
    localparam int NUM_CH     = 4;

    // Default counter width kept for rise timestamps
    localparam int STAMP_BITS_DEFAULT = 16;

    // APB register map: register i at byte address 4*i
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_PASSTHROUGH = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_FIXED_A     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FIXED_B     = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_WRAP_ADD    = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SW_A_ON     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_SW_A_OFF    = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_SW_B_ON     = 3'd6;

    // Reset values
    localparam logic [WIDTH_BITS-1:0] DRIVE_RESET    = 16'd940;
    localparam logic [WIDTH_BITS-1:0] WRAP_RESET     = 16'd2499;
    localparam logic [WIDTH_BITS-1:0] SW_A_ON_RESET  = 16'd1720;
    localparam logic [WIDTH_BITS-1:0] SW_A_OFF_RESET = 16'd1420;
    localparam logic [WIDTH_BITS-1:0] SW_B_ON_RESET  = 16'd1620;

    // Channel roles
    localparam logic [CH_BITS-1:0] CH_DRIVE_A = 2'd0;
    localparam logic [CH_BITS-1:0] CH_DRIVE_B = 2'd1;
    localparam logic [CH_BITS-1:0] CH_SWITCH_A = 2'd2;
    localparam logic [CH_BITS-1:0] CH_SWITCH_B = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic                  passthrough;
        logic [WIDTH_BITS-1:0] fixed_a;
        logic [WIDTH_BITS-1:0] fixed_b;
        logic [WIDTH_BITS-1:0] wrap_add;
        logic [WIDTH_BITS-1:0] sw_a_on;
        logic [WIDTH_BITS-1:0] sw_a_off;
        logic [WIDTH_BITS-1:0] sw_b_on;
    } t_cfg;

    // Measurement produced by the edge tracker for one event
    typedef struct packed {
        logic                  done;
        logic [WIDTH_BITS-1:0] width;
    } t_meas;

endpackage

// ===== src/rc_pulse_width_capture.sv =====
// Four-channel RC pulse-width decoder, top level.
// Holds the input and result registers, drive and switch state.
// Depends on rpwc_pkg, rpwc_regs and rpwc_edge_track.
//
// One capture event (channel, counter value) enters per clock unless stalled;
// each event gives exactly one result beat via the input register and the
// result register, and the block keeps taking one beat per cycle as long as
// the result side does not stall. The rate is set by the single evaluate stage
// between the input register and the result register, where the per-channel
// state is read and updated in the same cycle. Channels alternate rise/fall;
// a fall yields width = fall - rise (plus wrap_add when fall is not past rise),
// low 16 bits. Channels 0/1 feed the drive outputs in passthrough mode and are
// ignored in manual mode; channel 2 drives a hysteretic switch, channel 3 a
// threshold switch. Write configuration only while no beat is in flight.
module rc_pulse_width_capture #(
    parameter int STAMP_BITS = rpwc_pkg::STAMP_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // capture event channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpwc_pkg::CH_BITS-1:0]        i_channel,
    input  logic [rpwc_pkg::COUNT_BITS-1:0]     i_captured_count,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_width_done,
    output logic [rpwc_pkg::WIDTH_BITS-1:0]     o_pulse_width,
    output logic [rpwc_pkg::WIDTH_BITS-1:0]     o_drive_a,
    output logic [rpwc_pkg::WIDTH_BITS-1:0]     o_drive_b,
    output logic                                o_switch_a,
    output logic                                o_switch_b,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpwc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [rpwc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [rpwc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    rpwc_pkg::t_cfg                        cfg;
    rpwc_pkg::t_meas                       meas;

    // input register
    logic                                  r_in_valid;
    logic [rpwc_pkg::CH_BITS-1:0]          r_ch;
    logic [rpwc_pkg::COUNT_BITS-1:0]       r_stamp;

    // decoder state
    logic [rpwc_pkg::WIDTH_BITS-1:0]       r_drive_a, n_drive_a;
    logic [rpwc_pkg::WIDTH_BITS-1:0]       r_drive_b, n_drive_b;
    logic [rpwc_pkg::WIDTH_BITS-1:0]       r_last_w3, n_last_w3;
    logic                                  r_sw_a, n_sw_a;

    // result register
    logic                                  r_out_valid;
    logic                                  r_out_done;
    logic [rpwc_pkg::WIDTH_BITS-1:0]       r_out_width;
    logic [rpwc_pkg::WIDTH_BITS-1:0]       r_out_drive_a;
    logic [rpwc_pkg::WIDTH_BITS-1:0]       r_out_drive_b;
    logic                                  r_out_sw_a;
    logic                                  r_out_sw_b;

    logic                                  advance;
    logic                                  in_accept;
    logic                                  ignored;
    logic                                  fire;

    rpwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: evaluate stage moves when the result register is free
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Manual mode drops drive channel events
    assign ignored = !cfg.passthrough &&
                     ((r_ch == rpwc_pkg::CH_DRIVE_A) || (r_ch == rpwc_pkg::CH_DRIVE_B));
    assign fire    = r_in_valid && advance && !ignored;

    rpwc_edge_track #(
        .STAMP_BITS (STAMP_BITS)
    ) u_edge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_ch       (r_ch),
        .i_stamp    (r_stamp),
        .i_wrap_add (cfg.wrap_add),
        .o_meas     (meas)
    );

    // Next state from a completed measurement
    always_comb begin
        n_drive_a = r_drive_a;
        n_drive_b = r_drive_b;
        n_last_w3 = r_last_w3;
        n_sw_a    = r_sw_a;
        if (meas.done) begin
            case (r_ch)
                rpwc_pkg::CH_DRIVE_A:  n_drive_a = meas.width;
                rpwc_pkg::CH_DRIVE_B:  n_drive_b = meas.width;
                rpwc_pkg::CH_SWITCH_A: begin
                    if (meas.width > cfg.sw_a_on) begin
                        n_sw_a = 1'b1;
                    end else if (meas.width < cfg.sw_a_off) begin
                        n_sw_a = 1'b0;
                    end
                end
                default:               n_last_w3 = meas.width;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch    <= i_channel;
            r_stamp <= i_captured_count;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_a <= rpwc_pkg::DRIVE_RESET;
            r_drive_b <= rpwc_pkg::DRIVE_RESET;
            r_last_w3 <= '0;
            r_sw_a    <= 1'b0;
        end else begin
            r_drive_a <= n_drive_a;
            r_drive_b <= n_drive_b;
            r_last_w3 <= n_last_w3;
            r_sw_a    <= n_sw_a;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_done    <= meas.done;
            r_out_width   <= meas.width;
            r_out_drive_a <= cfg.passthrough ? n_drive_a : cfg.fixed_a;
            r_out_drive_b <= cfg.passthrough ? n_drive_b : cfg.fixed_b;
            r_out_sw_a    <= n_sw_a;
            r_out_sw_b    <= n_last_w3 > cfg.sw_b_on;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_width_done  = r_out_done;
    assign o_pulse_width = r_out_width;
    assign o_drive_a     = r_out_drive_a;
    assign o_drive_b     = r_out_drive_b;
    assign o_switch_a    = r_out_sw_a;
    assign o_switch_b    = r_out_sw_b;

    // Checks
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    a_width_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> (r_out_width == '0))
        else $error("nonzero width without a completed measurement");

    a_manual_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !cfg.passthrough) |->
            (r_out_drive_a == cfg.fixed_a && r_out_drive_b == cfg.fixed_b))
        else $error("manual mode drive mismatch");

    a_ignored_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && ignored) |=> (r_out_valid && !r_out_done))
        else $error("ignored event completed a measurement");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

endmodule

// ===== src/rpwc_regs.sv =====
// APB configuration registers of the pulse-width capture block.
// Depends on rpwc_pkg.
module rpwc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpwc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [rpwc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [rpwc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output rpwc_pkg::t_cfg                      o_cfg
);

    rpwc_pkg::t_cfg                         r_cfg;
    logic                                   wr_en;
    logic [rpwc_pkg::REG_IDX_BITS-1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[rpwc_pkg::APB_ADDR_BITS-1:2];
    assign o_cfg   = r_cfg;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.passthrough <= 1'b1;
            r_cfg.fixed_a     <= rpwc_pkg::DRIVE_RESET;
            r_cfg.fixed_b     <= rpwc_pkg::DRIVE_RESET;
            r_cfg.wrap_add    <= rpwc_pkg::WRAP_RESET;
            r_cfg.sw_a_on     <= rpwc_pkg::SW_A_ON_RESET;
            r_cfg.sw_a_off    <= rpwc_pkg::SW_A_OFF_RESET;
            r_cfg.sw_b_on     <= rpwc_pkg::SW_B_ON_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                rpwc_pkg::REG_PASSTHROUGH: r_cfg.passthrough <= pwdata[0];
                rpwc_pkg::REG_FIXED_A:     r_cfg.fixed_a     <= pwdata[15:0];
                rpwc_pkg::REG_FIXED_B:     r_cfg.fixed_b     <= pwdata[15:0];
                rpwc_pkg::REG_WRAP_ADD:    r_cfg.wrap_add    <= pwdata[15:0];
                rpwc_pkg::REG_SW_A_ON:     r_cfg.sw_a_on     <= pwdata[15:0];
                rpwc_pkg::REG_SW_A_OFF:    r_cfg.sw_a_off    <= pwdata[15:0];
                rpwc_pkg::REG_SW_B_ON:     r_cfg.sw_b_on     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rpwc_pkg::REG_PASSTHROUGH: prdata = {31'd0, r_cfg.passthrough};
            rpwc_pkg::REG_FIXED_A:     prdata = {16'd0, r_cfg.fixed_a};
            rpwc_pkg::REG_FIXED_B:     prdata = {16'd0, r_cfg.fixed_b};
            rpwc_pkg::REG_WRAP_ADD:    prdata = {16'd0, r_cfg.wrap_add};
            rpwc_pkg::REG_SW_A_ON:     prdata = {16'd0, r_cfg.sw_a_on};
            rpwc_pkg::REG_SW_A_OFF:    prdata = {16'd0, r_cfg.sw_a_off};
            rpwc_pkg::REG_SW_B_ON:     prdata = {16'd0, r_cfg.sw_b_on};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== src/rpwc_edge_track.sv =====
// Per-channel edge tracking: rise/fall phase, rise timestamps, width math.
// Depends on rpwc_pkg.
module rpwc_edge_track #(
    parameter int STAMP_BITS = rpwc_pkg::STAMP_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  logic [rpwc_pkg::CH_BITS-1:0]       i_ch,
    input  logic [rpwc_pkg::COUNT_BITS-1:0]    i_stamp,
    input  logic [rpwc_pkg::WIDTH_BITS-1:0]    i_wrap_add,
    output rpwc_pkg::t_meas                    o_meas
);

    // Timestamp bits actually kept: the counter field caps it
    localparam int SW = (STAMP_BITS < rpwc_pkg::COUNT_BITS) ? STAMP_BITS
                                                             : rpwc_pkg::COUNT_BITS;

    logic [rpwc_pkg::NUM_CH-1:0]       r_expect_rise;
    logic [SW-1:0]                     r_rise [rpwc_pkg::NUM_CH];

    logic [SW-1:0]                     stamp;
    logic [SW-1:0]                     rise;
    logic                              is_fall;
    logic [rpwc_pkg::WIDTH_BITS-1:0]   diff;
    logic [rpwc_pkg::WIDTH_BITS-1:0]   wrap;

    assign stamp   = i_stamp[SW-1:0];
    assign rise    = r_rise[i_ch];
    assign is_fall = !r_expect_rise[i_ch];

    // Width = fall - rise, plus the wrap amount when fall is not past rise
    assign diff = rpwc_pkg::WIDTH_BITS'(stamp) - rpwc_pkg::WIDTH_BITS'(rise);
    assign wrap = (stamp <= rise) ? i_wrap_add : '0;

    assign o_meas.done  = i_fire && is_fall;
    assign o_meas.width = (i_fire && is_fall) ? diff + wrap : '0;

    // Phase bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_rise <= '1;
        end else if (i_fire) begin
            r_expect_rise[i_ch] <= is_fall;
        end
    end

    // Rise timestamps, written on a rising edge only
    always_ff @(posedge i_clk) begin
        if (i_fire && !is_fall) begin
            r_rise[i_ch] <= stamp;
        end
    end

endmodule
